// ----- hw/rtl/stfsi_pkg.sv -----
// Shared types and result codes for the sorted table find/swap/insert block.
package stfsi_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_SWAPPED  = 3'd1,
        ST_LAST     = 3'd2,
        ST_INSERTED = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    // Request command codes (bit 0 of the command field).
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PROBE = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_SWAP  = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_SPARE = 7'b1000000
    } t_state;

endpackage

// ----- hw/rtl/sorted_table_find_swap_or_insert.sv -----
// Sorted table with append, binary-search lookup, swap-with-successor and sorted insert.
// Sequence after accept: append goes straight to the done state; lookup runs search probes,
//   each a probe then a compare, then ends found last, swaps, refuses when full, or shifts and inserts.
// One request at a time: o_stall is high from accept until the result is loaded, and any
//   output stall holds it high longer.
// Reset: entry count cleared (table empty); store not cleared, only read below the count.
module sorted_table_find_swap_or_insert #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_command,
    input  logic signed [31:0] i_key_value,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic [5:0]         o_position,
    output logic [6:0]         o_table_length
);
    import stfsi_pkg::*;

    // AW indexes the store, CW holds a count from 0 to CAPACITY.
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // ------------------------------------------------------------------
    // Entry store: one write port, one read port with registered data.
    // ------------------------------------------------------------------
    logic signed [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_rdata;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic signed [31:0] mem_wd;
    logic [AW-1:0]      mem_ra;

    // Read-first: a read and a write to the same address return the old data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;   // valid entries
    logic [CW-1:0]      r_lo, n_lo;         // search window [lo, hi1)
    logic [CW-1:0]      r_hi1, n_hi1;
    logic [CW-1:0]      r_mid, n_mid;       // probe index
    logic [CW-1:0]      r_rr, n_rr;         // shift: next destination slot
    logic               r_pend, n_pend;     // shift: read data waits to be written
    logic signed [31:0] r_key, n_key;
    t_status            r_res_st, n_res_st;
    logic [CW-1:0]      r_res_idx, n_res_idx;

    // Output register
    logic               r_out_valid, n_out_valid;
    t_status            r_out_st, n_out_st;
    logic [CW-1:0]      r_out_idx, n_out_idx;
    logic [CW-1:0]      r_out_len, n_out_len;

    // Shared datapath values
    logic [CW:0]        w_sum;
    logic [CW-1:0]      w_mid;
    logic [CW-1:0]      w_mid1;
    logic [CW-1:0]      w_rr_up;
    logic [CW-1:0]      w_rr_dn;
    logic               w_full;
    logic [CW+5:0]      w_pos_ext;
    logic [CW+6:0]      w_len_ext;

    // Midpoint floor((lo + hi) / 2) with hi = hi1 - 1; only used while lo < hi1.
    assign w_sum   = {1'b0, r_lo} + {1'b0, r_hi1} - (CW + 1)'(1);
    assign w_mid   = w_sum[CW:1];
    assign w_mid1  = r_mid + CW'(1);
    assign w_rr_up = r_rr + CW'(1);
    assign w_rr_dn = r_rr - CW'(1);
    assign w_full  = (r_count >= CW'(CAPACITY));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi1       = r_hi1;
        n_mid       = r_mid;
        n_rr        = r_rr;
        n_pend      = r_pend;
        n_key       = r_key;
        n_res_st    = r_res_st;
        n_res_idx   = r_res_idx;
        n_out_valid = r_out_valid;
        n_out_st    = r_out_st;
        n_out_idx   = r_out_idx;
        n_out_len   = r_out_len;
        mem_we      = 1'b0;
        mem_wa      = r_mid[AW-1:0];
        mem_wd      = r_key;
        mem_ra      = r_mid[AW-1:0];

        // result taken downstream
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_key = i_key_value;
                    if (i_command == CMD_APPEND) begin
                        n_state = S_DONE;
                        if (w_full) begin
                            n_res_st  = ST_FULL;
                            n_res_idx = '0;
                        end else begin
                            mem_we    = 1'b1;
                            mem_wa    = r_count[AW-1:0];
                            mem_wd    = i_key_value;
                            n_count   = r_count + CW'(1);
                            n_res_st  = ST_APPENDED;
                            n_res_idx = r_count;
                        end
                    end else begin
                        n_lo    = '0;
                        n_hi1   = r_count;
                        n_state = S_PROBE;
                    end
                end
            end

            S_PROBE: begin
                if (r_lo < r_hi1) begin
                    n_mid   = w_mid;
                    mem_ra  = w_mid[AW-1:0];
                    n_state = S_CMP;
                end else if (w_full) begin
                    n_res_st  = ST_FULL;
                    n_res_idx = '0;
                    n_state   = S_DONE;
                end else begin
                    // key absent: open a hole at lo by moving entries up
                    n_rr    = r_count;
                    n_pend  = 1'b0;
                    n_state = S_SHIFT;
                end
            end

            S_CMP: begin
                if (r_rdata == r_key) begin
                    n_res_idx = r_mid;
                    if (w_mid1 >= r_count) begin
                        n_res_st = ST_LAST;
                        n_state  = S_DONE;
                    end else begin
                        // fetch successor and overwrite it with the key in the same cycle
                        mem_ra   = w_mid1[AW-1:0];
                        mem_we   = 1'b1;
                        mem_wa   = w_mid1[AW-1:0];
                        mem_wd   = r_key;
                        n_res_st = ST_SWAPPED;
                        n_state  = S_SWAP;
                    end
                end else begin
                    if (r_key < r_rdata) begin
                        n_hi1 = r_mid;
                    end else begin
                        n_lo = w_mid1;
                    end
                    n_state = S_PROBE;
                end
            end

            S_SWAP: begin
                mem_we  = 1'b1;
                mem_wa  = r_mid[AW-1:0];
                mem_wd  = r_rdata;
                n_state = S_DONE;
            end

            S_SHIFT: begin
                // pipelined move: write the entry read last cycle, read the next one
                if (r_pend) begin
                    mem_we = 1'b1;
                    mem_wa = w_rr_up[AW-1:0];
                    mem_wd = r_rdata;
                end
                if (r_rr > r_lo) begin
                    mem_ra = w_rr_dn[AW-1:0];
                    n_pend = 1'b1;
                    n_rr   = w_rr_dn;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        mem_we    = 1'b1;
                        mem_wa    = r_lo[AW-1:0];
                        mem_wd    = r_key;
                        n_count   = r_count + CW'(1);
                        n_res_st  = ST_INSERTED;
                        n_res_idx = r_lo;
                        n_state   = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_res_st;
                    n_out_idx   = r_res_idx;
                    n_out_len   = r_count;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_hi1     <= n_hi1;
        r_mid     <= n_mid;
        r_rr      <= n_rr;
        r_key     <= n_key;
        r_res_st  <= n_res_st;
        r_res_idx <= n_res_idx;
        r_out_st  <= n_out_st;
        r_out_idx <= n_out_idx;
        r_out_len <= n_out_len;
    end

    // Position and length are reported in their low 6 and 7 bits.
    assign w_pos_ext = {6'b0, r_out_idx};
    assign w_len_ext = {7'b0, r_out_len};

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_status       = r_out_st;
    assign o_position     = w_pos_ext[5:0];
    assign o_table_length = w_len_ext[6:0];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CW'(1)))
        else $error("entry count moved by other than one");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("sequencer idle right after accepting a request");

    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_lo <= r_hi1) && (r_hi1 <= r_count))
        else $error("search window out of order");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result registered outside the done state");

endmodule

// ----- tb/sorted_table_find_swap_or_insert_tb.sv -----
// Self-checking testbench for the sorted table find/swap/insert block.
module sorted_table_find_swap_or_insert_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stfsi_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 880;
    // No idling on either side once this few requests/results remain.
    localparam int QUIET_TAIL   = 80;
    // Receiver holds off once, after this many results, for this long.
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 500;
    // Worst request is a full-length shift plus the search.
    localparam int DRAIN_CYCLES = 200;
    // Leave a wide margin over the slowest legal run.
    localparam int CYCLE_LIMIT  = 500000;

    // One request as the sender offers it.
    typedef struct {
        logic               cmd;
        logic signed [31:0] key;
        bit                 drain_first;  // hold until every result is back, except during the receiver hold-off
    } t_request;

    // One expected result.
    typedef struct packed {
        t_status    status;
        logic [5:0] position;
        logic [6:0] length;
    } t_outcome;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    logic               i_command   = CMD_APPEND;
    logic signed [31:0] i_key_value = '0;
    logic               o_valid;
    logic               i_stall     = 1'b0;
    logic [2:0]         o_status;
    logic [5:0]         o_position;
    logic [6:0]         o_table_length;

    sorted_table_find_swap_or_insert #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_key_value    (i_key_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_position     (o_position),
        .o_table_length (o_table_length)
    );

    // Shadow copy of the table. Only entries below shadow_count are ever read.
    logic signed [31:0] shadow_entries [CAPACITY];
    int                 shadow_count = 0;

    t_request request_q [$];   // requests not yet offered
    t_outcome outcome_q [$];   // results owed by the block, oldest first

    int errors       = 0;
    int total_items  = 0;
    int results_seen = 0;
    int cycle_cnt    = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one accepted request to the shadow table and queue its result.
    // Lookup is a binary search that stops at the first probe hitting an equal
    // entry; an out-of-order table is searched exactly the same way.
    task automatic table_apply_request(input logic cmd, input logic signed [31:0] key);
        int       lo;
        int       hi;
        int       mid;
        int       i;
        int       pos;
        bit       hit;
        t_status  st;
        t_outcome res;
        logic signed [31:0] tmp;
        hit = 1'b0;
        pos = 0;
        st  = ST_FULL;
        if (cmd == CMD_APPEND) begin
            // Full table: nothing written, position reads 0.
            if (shadow_count < CAPACITY) begin
                shadow_entries[shadow_count] = key;
                pos = shadow_count;
                shadow_count++;
                st = ST_APPENDED;
            end
        end else begin
            lo = 0;
            hi = shadow_count - 1;
            while (!hit && lo <= hi) begin
                mid = (lo + hi) / 2;
                if (shadow_entries[mid] == key) begin
                    hit = 1'b1;
                    pos = mid;
                    if (mid + 1 >= shadow_count) begin
                        // Found as last entry: no successor to trade with.
                        st = ST_LAST;
                    end else begin
                        tmp = shadow_entries[mid];
                        shadow_entries[mid] = shadow_entries[mid + 1];
                        shadow_entries[mid + 1] = tmp;
                        st = ST_SWAPPED;
                    end
                end else if (key < shadow_entries[mid]) begin
                    hi = mid - 1;
                end else begin
                    lo = mid + 1;
                end
            end
            // Absent key goes to the final left bound, unless the table is full.
            if (!hit && shadow_count < CAPACITY) begin
                for (i = shadow_count; i > lo; i--)
                    shadow_entries[i] = shadow_entries[i - 1];
                shadow_entries[lo] = key;
                shadow_count++;
                pos = lo;
                st = ST_INSERTED;
            end
        end
        res.status   = st;
        res.position = pos[5:0];
        res.length   = shadow_count[6:0];
        outcome_q.push_back(res);
    endtask

    // Receiver state, shared with the driver so the long hold-off keeps
    // requests coming.
    int       rx_hold_left  = 0;
    bit       rx_hold_done  = 1'b0;
    int       rx_stall_left = 0;
    int       rx_calm       = 0;
    int       rx_r;
    bit       rx_next;
    t_outcome want;

    // Request driver. A request is predicted at the edge where it is taken;
    // the next one (or an idle gap) is put up at that same edge.
    int       tx_gap  = 0;
    int       tx_calm = 0;
    int       tx_r;
    bit       tx_taken;
    t_request tx_next;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_command   <= CMD_APPEND;
            i_key_value <= '0;
        end else begin
            tx_taken = i_valid && !o_stall;
            if (tx_taken)
                table_apply_request(i_command, i_key_value);
            if (!i_valid || tx_taken) begin
                if (tx_gap > 0 && request_q.size() >= QUIET_TAIL) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (request_q.size() == 0 ||
                             (request_q[0].drain_first && outcome_q.size() != 0 &&
                              rx_hold_left == 0)) begin
                    // Nothing left, or a pause until the block has caught up.
                    i_valid <= 1'b0;
                end else begin
                    tx_next     = request_q.pop_front();
                    i_valid     <= 1'b1;
                    i_command   <= tx_next.cmd;
                    i_key_value <= tx_next.key;
                    // Gap after this request: random bursts, some calm stretches.
                    if (tx_calm > 0) begin
                        tx_calm--;
                    end else begin
                        tx_r = $urandom_range(15);
                        if (tx_r == 0)
                            tx_calm = $urandom_range(20, 80);
                        else if (tx_r < 4)
                            tx_gap = $urandom_range(1, 17);
                    end
                end
            end
        end
    end

    // Result monitor and receiver stall. Each taken result is checked against
    // the oldest expectation; the stall for the next cycle is chosen after.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (outcome_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, status %0d position %0d length %0d",
                             $realtime, o_status, o_position, o_table_length);
                end else begin
                    want = outcome_q.pop_front();
                    if (o_status !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, want.status, o_status);
                    end
                    if (o_position !== want.position) begin
                        errors++;
                        $display("%0t: position expected %0d actual %0d",
                                 $realtime, want.position, o_position);
                    end
                    if (o_table_length !== want.length) begin
                        errors++;
                        $display("%0t: table_length expected %0d actual %0d",
                                 $realtime, want.length, o_table_length);
                    end
                end
                results_seen++;
            end

            rx_next = 1'b0;
            if (rx_hold_left > 0) begin
                // Long hold-off: block fills and must stall the sender.
                rx_hold_left--;
                rx_next = 1'b1;
            end else if (!rx_hold_done && results_seen >= HOLD_AT) begin
                rx_hold_done = 1'b1;
                rx_hold_left = HOLD_CYCLES - 1;
                rx_next = 1'b1;
            end else if (results_seen >= total_items - QUIET_TAIL) begin
                rx_next = 1'b0;
            end else if (rx_stall_left > 0) begin
                rx_stall_left--;
                rx_next = 1'b1;
            end else if (rx_calm > 0) begin
                rx_calm--;
            end else begin
                rx_r = $urandom_range(15);
                if (rx_r == 0) begin
                    rx_calm = $urandom_range(20, 80);
                end else if (rx_r < 4) begin
                    rx_stall_left = $urandom_range(0, 16);
                    rx_next = 1'b1;
                end
            end
            i_stall <= rx_next;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d requests unsent, %0d results owed",
                     $realtime, request_q.size(), outcome_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus: a directed opening, then weighted random requests.
    initial begin
        t_request           req;
        logic signed [31:0] key_pool [$];
        logic signed [31:0] tail_key;
        int                 n;
        int                 r;

        // Directed: empty-table insert, found-last, swap into disorder,
        // extremes of the key, duplicates, alternating bit patterns.
        req.drain_first = 1'b0;
        key_pool = '{32'sd100, 32'sd100, 32'sd200, 32'sd100, 32'sd100,
                     32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                     32'sd0, -32'sd1, 32'sd0, 32'sd0, 32'sd100, 32'sd100,
                     32'sh5555_5555, 32'shAAAA_AAAA, -32'sd1, 32'sh8000_0000,
                     32'sd150};
        for (n = 0; n < key_pool.size(); n++) begin
            // Appends at 200, both extremes, the duplicate 0 and 100, and -1.
            req.cmd = (n == 2 || n == 5 || n == 6 || n == 11 || n == 13 || n == 17)
                      ? CMD_APPEND : CMD_LOOKUP;
            req.key = key_pool[n];
            request_q.push_back(req);
        end

        // Random: mostly lookups of keys already sent (swaps and found-last),
        // a trickle of appends and absent-key inserts so the table fills
        // part way through and full refusals follow.
        tail_key = -32'sd1000000;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(99);
            req.drain_first = (n == 0) || ($urandom_range(49) == 0);
            if (r < 6) begin
                req.cmd = CMD_APPEND;
                if (r < 3) begin
                    tail_key = tail_key + $urandom_range(1, 4096);
                    req.key = tail_key;
                end else if (r < 5) begin
                    req.key = $urandom;
                end else begin
                    req.key = key_pool[$urandom_range(key_pool.size() - 1)];
                end
            end else if (r < 12) begin
                req.cmd = CMD_LOOKUP;
                req.key = $urandom;
            end else begin
                req.cmd = CMD_LOOKUP;
                req.key = key_pool[$urandom_range(key_pool.size() - 1)];
            end
            if (r < 12)
                key_pool.push_back(req.key);
            request_q.push_back(req);
        end
        total_items = request_q.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || i_valid || outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
